@@ hdl/fpsr_pkg.sv @@
`default_nettype none
package fpsr_pkg;

  localparam int LEVEL_W    = 8;
  localparam int PCT_W      = 7;
  localparam int TIME_W     = 16;
  localparam int PROD_W     = 24;
  localparam int QUO_W      = 8;
  localparam int STEP_W     = 5;
  localparam int CNT_W      = 3;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int RECIP_IN_W  = 15;
  localparam int RECIP_K_W   = 13;
  localparam int RECIP_W     = 28;
  localparam int RECIP_SHIFT = 19;

  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_SET  = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_PWM     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PWM     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAN_ENABLED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_TIME   = 2'd3;

  localparam logic [LEVEL_W-1:0] MIN_PWM_RST     = 8'd0;
  localparam logic [LEVEL_W-1:0] MAX_PWM_RST     = 8'd255;
  localparam logic [TIME_W-1:0]  RAMP_TIME_RST   = 16'd300;
  localparam logic [7:0]         PCT_LIMIT       = 8'd100;
  localparam logic [TIME_W-1:0]  PCT_DIVISOR     = 16'd100;
  localparam logic [CNT_W-1:0]   DIV_LAST        = 3'd7;

  // Multiplying by 5243 and shifting right by 19 divides exactly by 100 for
  // every product of span and percent.
  localparam logic [RECIP_K_W-1:0] PCT_RECIP     = 13'd5243;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_EMIT      = 5'd0;
  localparam step_t S_WAIT      = 5'd1;
  localparam step_t S_DEC_STOP  = 5'd2;
  localparam step_t S_DEC_SET   = 5'd3;
  localparam step_t S_DEC_TICK  = 5'd4;
  localparam step_t S_DEC_TGT   = 5'd5;
  localparam step_t S_ELAPSE    = 5'd6;
  localparam step_t S_DEC_END   = 5'd7;
  localparam step_t S_TICK_MUL  = 5'd8;
  localparam step_t S_TICK_LOAD = 5'd9;
  localparam step_t S_TICK_DIV  = 5'd10;
  localparam step_t S_TICK_WB   = 5'd11;
  localparam step_t S_STOP      = 5'd12;
  localparam step_t S_SET_MUL   = 5'd13;
  localparam step_t S_SET_SCALE = 5'd14;
  localparam step_t S_SET_WB    = 5'd15;
  localparam step_t S_HOLD      = 5'd16;
  localparam step_t S_ARRIVE    = 5'd17;

  typedef enum logic [3:0] {
    U_NOP,
    U_EMIT,
    U_WAIT,
    U_ELAPSE,
    U_TICK_MUL,
    U_DIV_LOAD,
    U_DIV_STEP,
    U_TICK_WB,
    U_CLEAR,
    U_SET_MUL,
    U_SET_SCALE,
    U_SET_WB,
    U_SET_READY,
    U_ARRIVE
  } uop_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_OUT_BUSY,
    C_NO_INPUT,
    C_OP_STOP,
    C_OP_SET,
    C_NO_TICK,
    C_AT_TARGET,
    C_RAMP_END,
    C_DIV_MORE
  } cond_t;

  typedef struct packed {
    uop_t  uop;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode_rom(input step_t step);
    case (step)
      S_EMIT:      return '{U_EMIT,      C_OUT_BUSY,  S_EMIT};
      S_WAIT:      return '{U_WAIT,      C_NO_INPUT,  S_WAIT};
      S_DEC_STOP:  return '{U_NOP,       C_OP_STOP,   S_STOP};
      S_DEC_SET:   return '{U_NOP,       C_OP_SET,    S_SET_MUL};
      S_DEC_TICK:  return '{U_NOP,       C_NO_TICK,   S_EMIT};
      S_DEC_TGT:   return '{U_NOP,       C_AT_TARGET, S_HOLD};
      S_ELAPSE:    return '{U_ELAPSE,    C_NEVER,     S_EMIT};
      S_DEC_END:   return '{U_NOP,       C_RAMP_END,  S_ARRIVE};
      S_TICK_MUL:  return '{U_TICK_MUL,  C_NEVER,     S_EMIT};
      S_TICK_LOAD: return '{U_DIV_LOAD,  C_NEVER,     S_EMIT};
      S_TICK_DIV:  return '{U_DIV_STEP,  C_DIV_MORE,  S_TICK_DIV};
      S_TICK_WB:   return '{U_TICK_WB,   C_ALWAYS,    S_EMIT};
      S_STOP:      return '{U_CLEAR,     C_ALWAYS,    S_EMIT};
      S_SET_MUL:   return '{U_SET_MUL,   C_NEVER,     S_EMIT};
      S_SET_SCALE: return '{U_SET_SCALE, C_NEVER,     S_EMIT};
      S_SET_WB:    return '{U_SET_WB,    C_ALWAYS,    S_EMIT};
      S_HOLD:      return '{U_SET_READY, C_ALWAYS,    S_EMIT};
      S_ARRIVE:    return '{U_ARRIVE,    C_ALWAYS,    S_EMIT};
      default:     return '{U_NOP,       C_ALWAYS,    S_EMIT};
    endcase
  endfunction

endpackage
`default_nettype wire

@@ hdl/fan_pwm_soft_start_ramp_core.sv @@
// Input transactions are handled one at a time: a new one is taken only after the result
// of the previous one has been loaded into the result register, and a result that has
// not been taken stalls the sequencer before it loads the next.
// The longest path is set by the eight-step restoring divider of the ramp tick.
// Synchronous active-low reset restores the configuration defaults, clears the fan
// state and the result valid flag, and leaves the sequencer waiting for input.
`default_nettype none
module fan_pwm_soft_start_ramp_core
  import fpsr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [OP_W-1:0]       in_operation,
  input  wire logic [7:0]            in_percent,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [LEVEL_W-1:0]         out_pwm_level,
  output logic                       out_ready_res,
  output logic [PCT_W-1:0]           out_speed_percent
);

  logic [LEVEL_W-1:0] min_pwm_r, min_pwm_nxt;
  logic [LEVEL_W-1:0] max_pwm_r, max_pwm_nxt;
  logic               fan_enabled_r, fan_enabled_nxt;
  logic [TIME_W-1:0]  ramp_time_r, ramp_time_nxt;

  step_t              step_r, step_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [PCT_W-1:0]   pct_r, pct_nxt;

  logic [LEVEL_W-1:0] cur_r, cur_nxt;
  logic [LEVEL_W-1:0] tgt_r, tgt_nxt;
  logic [LEVEL_W-1:0] start_r, start_nxt;
  logic [TIME_W-1:0]  elapsed_r, elapsed_nxt;
  logic               ready_r, ready_nxt;
  logic [PCT_W-1:0]   held_r, held_nxt;

  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [TIME_W-1:0]  divisor_r, divisor_nxt;
  logic [TIME_W-1:0]  rem_r, rem_nxt;
  logic [QUO_W-1:0]   dq_r, dq_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               neg_r, neg_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0] out_level_r, out_level_nxt;
  logic               out_rdy_r, out_rdy_nxt;
  logic [PCT_W-1:0]   out_pct_r, out_pct_nxt;

  ctrl_word_t         ctrl;
  logic               in_acc;
  logic               out_busy;
  logic               cond_hit;
  logic [LEVEL_W-1:0] span;
  logic [LEVEL_W:0]   diff;
  logic [LEVEL_W:0]   diff_neg;
  logic [LEVEL_W-1:0] diff_mag;
  logic [LEVEL_W-1:0] mul_a;
  logic [TIME_W-1:0]  mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [RECIP_W-1:0] recip_p;
  logic [TIME_W:0]    div_sh;
  logic [TIME_W:0]    div_sub;
  logic               div_q;
  logic [LEVEL_W-1:0] set_level;

  assign ctrl      = ucode_rom(step_r);
  assign in_ready  = (ctrl.uop == U_WAIT);
  assign in_acc    = in_valid && in_ready;
  assign out_busy  = out_valid_r && !out_ready;
  assign cfg_ready = 1'b1;

  assign span     = (max_pwm_r >= min_pwm_r) ? (max_pwm_r - min_pwm_r) : '0;
  assign diff     = {1'b0, tgt_r} - {1'b0, start_r};
  assign diff_neg = -diff;
  assign diff_mag = diff[LEVEL_W] ? diff_neg[LEVEL_W-1:0] : diff[LEVEL_W-1:0];
  assign mul_a    = (ctrl.uop == U_SET_MUL) ? span : diff_mag;
  assign mul_b    = (ctrl.uop == U_SET_MUL) ? {{(TIME_W-PCT_W){1'b0}}, pct_r} : elapsed_r;
  assign mul_p    = {{(PROD_W-LEVEL_W){1'b0}}, mul_a} * {{(PROD_W-TIME_W){1'b0}}, mul_b};
  assign recip_p  = {{(RECIP_W-RECIP_IN_W){1'b0}}, prod_r[RECIP_IN_W-1:0]} *
                    {{(RECIP_W-RECIP_K_W){1'b0}}, PCT_RECIP};

  assign div_sh   = {rem_r, dq_r[QUO_W-1]};
  assign div_sub  = div_sh - {1'b0, divisor_r};
  assign div_q    = (div_sh >= {1'b0, divisor_r});

  assign set_level = (pct_r == '0) ? '0 : (min_pwm_r + dq_r);

  always_comb begin
    case (ctrl.cond)
      C_NEVER:     cond_hit = 1'b0;
      C_ALWAYS:    cond_hit = 1'b1;
      C_OUT_BUSY:  cond_hit = out_busy;
      C_NO_INPUT:  cond_hit = !in_valid;
      C_OP_STOP:   cond_hit = (op_r == OP_STOP);
      C_OP_SET:    cond_hit = (op_r == OP_SET);
      C_NO_TICK:   cond_hit = (op_r != OP_TICK) || !fan_enabled_r;
      C_AT_TARGET: cond_hit = (cur_r == tgt_r);
      C_RAMP_END:  cond_hit = (elapsed_r >= ramp_time_r);
      C_DIV_MORE:  cond_hit = (cnt_r != '0);
      default:     cond_hit = 1'b1;
    endcase
    step_nxt = cond_hit ? ctrl.target : step_t'(step_r + 1'b1);
  end

  always_comb begin
    min_pwm_nxt     = min_pwm_r;
    max_pwm_nxt     = max_pwm_r;
    fan_enabled_nxt = fan_enabled_r;
    ramp_time_nxt   = ramp_time_r;
    op_nxt          = op_r;
    pct_nxt         = pct_r;
    cur_nxt         = cur_r;
    tgt_nxt         = tgt_r;
    start_nxt       = start_r;
    elapsed_nxt     = elapsed_r;
    ready_nxt       = ready_r;
    held_nxt        = held_r;
    prod_nxt        = prod_r;
    divisor_nxt     = divisor_r;
    rem_nxt         = rem_r;
    dq_nxt          = dq_r;
    cnt_nxt         = cnt_r;
    neg_nxt         = neg_r;
    out_valid_nxt   = out_busy;
    out_level_nxt   = out_level_r;
    out_rdy_nxt     = out_rdy_r;
    out_pct_nxt     = out_pct_r;

    if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_PWM:     min_pwm_nxt     = cfg_data[LEVEL_W-1:0];
        REG_MAX_PWM:     max_pwm_nxt     = cfg_data[LEVEL_W-1:0];
        REG_FAN_ENABLED: fan_enabled_nxt = cfg_data[0];
        REG_RAMP_TIME:   ramp_time_nxt   = cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end

    case (ctrl.uop)
      U_WAIT: begin
        if (in_acc) begin
          op_nxt  = in_operation;
          pct_nxt = (in_percent > PCT_LIMIT) ? PCT_LIMIT[PCT_W-1:0] : in_percent[PCT_W-1:0];
        end
      end
      U_EMIT: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = cur_r;
          out_rdy_nxt   = ready_r;
          out_pct_nxt   = held_r;
        end
      end
      U_ELAPSE: begin
        if (elapsed_r < ramp_time_r) begin
          elapsed_nxt = elapsed_r + 1'b1;
        end
      end
      U_TICK_MUL: begin
        prod_nxt    = mul_p;
        divisor_nxt = ramp_time_r;
        neg_nxt     = diff[LEVEL_W];
      end
      U_SET_MUL: begin
        prod_nxt    = mul_p;
        held_nxt    = pct_r;
        start_nxt   = cur_r;
        elapsed_nxt = '0;
      end
      U_SET_SCALE: begin
        dq_nxt = recip_p[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
      end
      U_DIV_LOAD: begin
        rem_nxt = prod_r[PROD_W-1:QUO_W];
        dq_nxt  = prod_r[QUO_W-1:0];
        cnt_nxt = DIV_LAST;
      end
      U_DIV_STEP: begin
        rem_nxt = div_q ? div_sub[TIME_W-1:0] : div_sh[TIME_W-1:0];
        dq_nxt  = {dq_r[QUO_W-2:0], div_q};
        cnt_nxt = cnt_r - 1'b1;
      end
      U_TICK_WB: begin
        cur_nxt = neg_r ? (start_r - dq_r) : (start_r + dq_r);
      end
      U_SET_WB: begin
        tgt_nxt   = set_level;
        ready_nxt = (cur_r == set_level);
      end
      U_SET_READY: begin
        ready_nxt = 1'b1;
      end
      U_ARRIVE: begin
        cur_nxt   = tgt_r;
        ready_nxt = 1'b1;
      end
      U_CLEAR: begin
        cur_nxt     = '0;
        tgt_nxt     = '0;
        start_nxt   = '0;
        elapsed_nxt = '0;
        ready_nxt   = 1'b0;
        held_nxt    = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pwm_r     <= MIN_PWM_RST;
      max_pwm_r     <= MAX_PWM_RST;
      fan_enabled_r <= 1'b1;
      ramp_time_r   <= RAMP_TIME_RST;
      step_r        <= S_WAIT;
      cur_r         <= '0;
      tgt_r         <= '0;
      start_r       <= '0;
      elapsed_r     <= '0;
      ready_r       <= 1'b0;
      held_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      min_pwm_r     <= min_pwm_nxt;
      max_pwm_r     <= max_pwm_nxt;
      fan_enabled_r <= fan_enabled_nxt;
      ramp_time_r   <= ramp_time_nxt;
      step_r        <= step_nxt;
      cur_r         <= cur_nxt;
      tgt_r         <= tgt_nxt;
      start_r       <= start_nxt;
      elapsed_r     <= elapsed_nxt;
      ready_r       <= ready_nxt;
      held_r        <= held_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    pct_r       <= pct_nxt;
    prod_r      <= prod_nxt;
    divisor_r   <= divisor_nxt;
    rem_r       <= rem_nxt;
    dq_r        <= dq_nxt;
    cnt_r       <= cnt_nxt;
    neg_r       <= neg_nxt;
    out_level_r <= out_level_nxt;
    out_rdy_r   <= out_rdy_nxt;
    out_pct_r   <= out_pct_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_pwm_level     = out_level_r;
  assign out_ready_res     = out_rdy_r;
  assign out_speed_percent = out_pct_r;

endmodule
`default_nettype wire

@@ hdl/fpsr_checker.sv @@
`default_nettype none
module fpsr_checker
  import fpsr_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [LEVEL_W-1:0] out_pwm_level,
  input wire logic               out_ready_res,
  input wire logic [PCT_W-1:0]   out_speed_percent
);

  logic [1:0] pend_r, pend_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign pend_nxt = 2'(pend_r + {1'b0, in_acc} - {1'b0, out_acc});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // A waiting result keeps its fields until the transaction completes.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pwm_level)
      && $stable(out_ready_res) && $stable(out_speed_percent))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without an input transaction");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 2'd2 |-> !in_ready)
    else $error("input taken with two results outstanding");

  a_percent_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_speed_percent <= PCT_LIMIT[PCT_W-1:0])
    else $error("speed percent above limit");

endmodule

bind fan_pwm_soft_start_ramp_core fpsr_checker u_fpsr_checker (.*);
`default_nettype wire
